@@ design/dsd_pkg.sv @@
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants of the direction switch debouncer: register
// indexes and reset values, reason codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package dsd_pkg;

   // default widths of the timestamp state and the pending counter
   localparam int TIME_BITS_DEFAULT  = 32;
   localparam int COUNT_BITS_DEFAULT = 8;

   // field widths
   localparam int MOVE_BITS      = 16;
   localparam int TIME_IN_BITS   = 32;
   localparam int DEAD_ZONE_BITS = 15;
   localparam int SAMPLES_BITS   = 8;
   localparam int MS_BITS        = 16;
   localparam int CSR_IDX_BITS   = 8;
   localparam int CSR_DATA_BITS  = 16;

   // register reset values
   localparam logic [DEAD_ZONE_BITS-1:0] DEAD_ZONE_RST  = 15'd256;
   localparam logic [SAMPLES_BITS-1:0]   SAMPLES_RST    = 8'd3;
   localparam logic [MS_BITS-1:0]        CONFIRM_MS_RST = 16'd100;
   localparam logic [MS_BITS-1:0]        HOLD_MS_RST    = 16'd500;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEAD_ZONE  = 8'd0,
      CSR_SAMPLES    = 8'd1,
      CSR_CONFIRM_MS = 8'd2,
      CSR_HOLD_MS    = 8'd3
   } csr_index_type;

   // request kinds
   typedef enum logic {
      REQ_MOVE  = 1'b0,
      REQ_PROBE = 1'b1
   } req_kind_type;

   // reason codes
   typedef enum logic [2:0] {
      RS_CENTER      = 3'd0,
      RS_HOLD_CENTER = 3'd1,
      RS_INITIAL     = 3'd2,
      RS_SAME        = 3'd3,
      RS_PENDING     = 3'd4,
      RS_CONFIRMED   = 3'd5,
      RS_PROBE       = 3'd6
   } reason_type;

   // direction codes, two bit signed
   localparam logic [1:0] DIR_CENTER = 2'b00;
   localparam logic [1:0] DIR_RIGHT  = 2'b01;
   localparam logic [1:0] DIR_LEFT   = 2'b11;

   // configuration register set
   typedef struct packed {
      logic [DEAD_ZONE_BITS-1:0] dead_zone;
      logic [SAMPLES_BITS-1:0]   confirm_samples;
      logic [MS_BITS-1:0]        confirm_ms;
      logic [MS_BITS-1:0]        hold_ms;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic       hold_valid;
      reason_type reason;
      logic [1:0] direction;
   } result_type;

endpackage

`default_nettype wire

@@ design/dsd_engine.sv @@
// ----------------------------------------------------------------------------
// dsd_engine
// Debounce state and the single pass decision logic: one item is evaluated
// combinationally against the held state, the state moves on at the step.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_engine #(
   parameter int TIME_BITS  = dsd_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = dsd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 step,
   input  wire logic                                 item_probe,
   input  wire logic signed [dsd_pkg::MOVE_BITS-1:0] item_move,
   input  wire logic [dsd_pkg::TIME_IN_BITS-1:0]     item_time,
   input  wire dsd_pkg::cfg_type                     cfg,
   output dsd_pkg::result_type                       result
);

   localparam int CMP_BITS = (COUNT_BITS > dsd_pkg::SAMPLES_BITS) ?
                             COUNT_BITS : dsd_pkg::SAMPLES_BITS;
   localparam int MV_BITS  = dsd_pkg::MOVE_BITS + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // debounce state
   logic                  stable_valid_ff, stable_valid_in;
   logic                  stable_neg_ff, stable_neg_in;
   logic [TIME_BITS-1:0]  stable_time_ff, stable_time_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_neg_ff, pend_neg_in;
   logic [TIME_BITS-1:0]  pend_start_ff, pend_start_in;
   logic [COUNT_BITS-1:0] pend_count_ff, pend_count_in;

   logic [TIME_BITS-1:0]     now;
   logic signed [MV_BITS-1:0] mv_ext;
   logic signed [MV_BITS-1:0] dz_ext;
   logic                     sign_pos;
   logic                     sign_neg;
   logic [1:0]               stable_dir;
   logic [1:0]               sample_dir;
   logic [TIME_BITS-1:0]     hold_age;
   logic [TIME_BITS-1:0]     pend_age;
   logic                     fresh;
   logic [COUNT_BITS-1:0]    count_inc;
   logic                     count_ok;
   logic                     time_ok;

   // sample sign and the age compares
   always_comb begin
      now        = TIME_BITS'(item_time);
      mv_ext     = {item_move[dsd_pkg::MOVE_BITS-1], item_move};
      dz_ext     = $signed({2'b00, cfg.dead_zone});
      sign_pos   = mv_ext > dz_ext;
      sign_neg   = mv_ext < -dz_ext;
      sample_dir = sign_neg ? dsd_pkg::DIR_LEFT : dsd_pkg::DIR_RIGHT;
      stable_dir = !stable_valid_ff ? dsd_pkg::DIR_CENTER :
                   (stable_neg_ff ? dsd_pkg::DIR_LEFT : dsd_pkg::DIR_RIGHT);
      hold_age   = now - stable_time_ff;
      pend_age   = now - pend_start_ff;
      fresh      = stable_valid_ff && (stable_time_ff != '0) &&
                   !((now > stable_time_ff) && (hold_age > TIME_BITS'(cfg.hold_ms)));
      count_inc  = (pend_count_ff == COUNT_MAX) ? pend_count_ff : pend_count_ff + 1'b1;
      count_ok   = CMP_BITS'(count_inc) >= CMP_BITS'(cfg.confirm_samples);
      time_ok    = (now >= pend_start_ff) && (pend_age >= TIME_BITS'(cfg.confirm_ms));
   end

   // decision and next state
   always_comb begin
      stable_valid_in   = stable_valid_ff;
      stable_neg_in     = stable_neg_ff;
      stable_time_in    = stable_time_ff;
      pend_valid_in     = pend_valid_ff;
      pend_neg_in       = pend_neg_ff;
      pend_start_in     = pend_start_ff;
      pend_count_in     = pend_count_ff;
      result.hold_valid = 1'b0;
      result.reason     = dsd_pkg::RS_CENTER;
      result.direction  = dsd_pkg::DIR_CENTER;
      if (item_probe) begin
         result.hold_valid = fresh;
         result.reason     = dsd_pkg::RS_PROBE;
         result.direction  = fresh ? stable_dir : dsd_pkg::DIR_CENTER;
      end else if (!sign_pos && !sign_neg) begin
         // centred sample drops any pending switch
         pend_valid_in    = 1'b0;
         pend_neg_in      = 1'b0;
         pend_start_in    = '0;
         pend_count_in    = '0;
         result.direction = stable_dir;
         result.reason    = stable_valid_ff ? dsd_pkg::RS_HOLD_CENTER : dsd_pkg::RS_CENTER;
      end else if (!stable_valid_ff || (sample_dir == stable_dir)) begin
         // first direction, or the held one seen again
         stable_valid_in  = 1'b1;
         stable_neg_in    = sign_neg;
         stable_time_in   = now;
         pend_valid_in    = 1'b0;
         pend_neg_in      = 1'b0;
         pend_start_in    = '0;
         pend_count_in    = '0;
         result.direction = sample_dir;
         result.reason    = stable_valid_ff ? dsd_pkg::RS_SAME : dsd_pkg::RS_INITIAL;
      end else if (!pend_valid_ff || (pend_neg_ff != sign_neg)) begin
         // opposite sign starts a new pending switch
         pend_valid_in    = 1'b1;
         pend_neg_in      = sign_neg;
         pend_start_in    = now;
         pend_count_in    = COUNT_BITS'(1);
         result.direction = stable_dir;
         result.reason    = dsd_pkg::RS_PENDING;
      end else if (count_ok && time_ok) begin
         // switch confirmed
         stable_neg_in    = sign_neg;
         stable_time_in   = now;
         pend_valid_in    = 1'b0;
         pend_neg_in      = 1'b0;
         pend_start_in    = '0;
         pend_count_in    = '0;
         result.direction = sample_dir;
         result.reason    = dsd_pkg::RS_CONFIRMED;
      end else begin
         pend_count_in    = count_inc;
         result.direction = stable_dir;
         result.reason    = dsd_pkg::RS_PENDING;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_valid_ff <= 1'b0;
         stable_neg_ff   <= 1'b0;
         stable_time_ff  <= '0;
         pend_valid_ff   <= 1'b0;
         pend_neg_ff     <= 1'b0;
         pend_start_ff   <= '0;
         pend_count_ff   <= '0;
      end else if (step) begin
         stable_valid_ff <= stable_valid_in;
         stable_neg_ff   <= stable_neg_in;
         stable_time_ff  <= stable_time_in;
         pend_valid_ff   <= pend_valid_in;
         pend_neg_ff     <= pend_neg_in;
         pend_start_ff   <= pend_start_in;
         pend_count_ff   <= pend_count_in;
      end
   end

   // a pending switch always carries a non-zero count
   a_pend_count : assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff == (pend_count_ff != '0))
      else $error("pending flag and count disagree");

   // a pending switch only exists against a stable direction
   a_pend_stable : assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> stable_valid_ff)
      else $error("pending switch without stable direction");

   // a confirmed switch leaves nothing pending
   a_confirm : assert property (@(posedge clock) disable iff (reset)
      step && !item_probe && (result.reason == dsd_pkg::RS_CONFIRMED)
      |=> stable_valid_ff && !pend_valid_ff)
      else $error("confirmed switch left state inconsistent");

   // move samples never report a hold
   a_hold_probe : assert property (@(posedge clock) disable iff (reset)
      step && !item_probe |-> !result.hold_valid)
      else $error("hold flag on a move sample");

endmodule

`default_nettype wire

@@ design/direction_switch_debouncer_top.sv @@
// ----------------------------------------------------------------------------
// direction_switch_debouncer_top
// Direction switch debouncer: turns signed move samples into a debounced
// direction sign with a reason code, and answers hold probes.
// ----------------------------------------------------------------------------
// Usage
//   req_ channel: one item a beat. req_tuser is the kind (0 move, 1 probe),
//   req_tdata carries the move value and the millisecond timestamp.
//   rsp_ channel: exactly one result beat per request beat, in order.
//   csr_ port: register writes by index; always ready. Write only while the
//   block is idle (nothing accepted still waiting to come out).
// Pipeline and throughput
//   A request beat is captured in an input register and evaluated
//   combinationally against the debounce state; the result register loads
//   as it advances, raising rsp_tvalid. One beat per cycle is sustained while
//   rsp_tready is high; the state update of one item is seen by the next.
// Reset
//   Synchronous, active high. Clears the debounce state (no stable
//   direction, nothing pending) and loads the register reset values.
// Stalls
//   While rsp_tready is low the result register holds; the input register
//   still takes one more beat, then req_tready drops until the result moves.
// ----------------------------------------------------------------------------
`default_nettype none

module direction_switch_debouncer_top #(
   parameter int TIME_BITS  = dsd_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = dsd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [47:0]                        req_tdata,  // move_value[15:0], time_ms[47:16]
   input  wire logic                               req_tuser,  // req_type[0]
   // result channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [7:0]                              rsp_tdata,  // direction[1:0], reason[4:2],
                                                               // hold_valid[5], zero[7:6]
   // register write port
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dsd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [dsd_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   dsd_pkg::cfg_type    cfg_ff, cfg_in;
   logic                in_valid_ff, in_valid_in;
   logic                in_probe_ff;
   logic signed [dsd_pkg::MOVE_BITS-1:0] in_move_ff;
   logic [dsd_pkg::TIME_IN_BITS-1:0]     in_time_ff;
   logic                out_valid_ff, out_valid_in;
   dsd_pkg::result_type out_res_ff;
   dsd_pkg::result_type result;
   logic                advance;
   logic                req_beat;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (dsd_pkg::csr_index_type'(csr_index))
            dsd_pkg::CSR_DEAD_ZONE:
               cfg_in.dead_zone = csr_data[dsd_pkg::DEAD_ZONE_BITS-1:0];
            dsd_pkg::CSR_SAMPLES:
               cfg_in.confirm_samples = csr_data[dsd_pkg::SAMPLES_BITS-1:0];
            dsd_pkg::CSR_CONFIRM_MS:
               cfg_in.confirm_ms = csr_data[dsd_pkg::MS_BITS-1:0];
            dsd_pkg::CSR_HOLD_MS:
               cfg_in.hold_ms = csr_data[dsd_pkg::MS_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone       <= dsd_pkg::DEAD_ZONE_RST;
         cfg_ff.confirm_samples <= dsd_pkg::SAMPLES_RST;
         cfg_ff.confirm_ms      <= dsd_pkg::CONFIRM_MS_RST;
         cfg_ff.hold_ms         <= dsd_pkg::HOLD_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake control
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      req_beat     = req_tvalid && req_tready;
      in_valid_in  = req_beat ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_probe_ff <= (dsd_pkg::req_kind_type'(req_tuser) == dsd_pkg::REQ_PROBE);
         in_move_ff  <= req_tdata[15:0];
         in_time_ff  <= req_tdata[47:16];
      end
   end

   // decision logic and state
   dsd_engine #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item_probe (in_probe_ff),
      .item_move  (in_move_ff),
      .item_time  (in_time_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_res_ff.hold_valid, out_res_ff.reason,
                        out_res_ff.direction};

   // a result leaves the evaluation stage only into a free result register
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready && in_valid_ff |=> $stable(out_res_ff))
      else $error("result overwritten while stalled");

   // direction code never takes the unused pattern
   a_dir_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'b10))
      else $error("invalid direction code");

   // the centre reason comes with the centre direction only
   a_center_dir : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_res_ff.reason == dsd_pkg::RS_CENTER)
      |-> (out_res_ff.direction == dsd_pkg::DIR_CENTER))
      else $error("centre reason with a direction");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for direction_switch_debouncer_top. A queue-fed driver
// sends move samples and hold probes, and a clocked monitor checks every
// result beat against an in-bench debounce predictor. Both sides idle at
// random but in one phase. Settings change between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CYCLES = 300000;
   localparam int SETTLE     = 6;

   // one request beat
   typedef struct packed {
      dsd_pkg::req_kind_type kind;
      logic [15:0]           move;
      logic [31:0]           stamp;
   } move_req_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [47:0]                       req_tdata = '0;
   logic                              req_tuser = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [7:0]                        rsp_tdata;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [dsd_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [dsd_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   direction_switch_debouncer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // predictor copy of registers and debounce state
   dsd_pkg::cfg_type cfg = '{dead_zone: dsd_pkg::DEAD_ZONE_RST,
                             confirm_samples: dsd_pkg::SAMPLES_RST,
                             confirm_ms: dsd_pkg::CONFIRM_MS_RST,
                             hold_ms: dsd_pkg::HOLD_MS_RST};
   bit          held_valid = 1'b0;
   bit          held_neg = 1'b0;
   logic [31:0] held_stamp = '0;
   bit          sw_valid = 1'b0;
   bit          sw_neg = 1'b0;
   logic [31:0] sw_start = '0;
   logic [7:0]  sw_count = '0;

   move_req_type        pending_reqs[$];
   dsd_pkg::result_type expected_results[$];
   int          sent_count = 0;
   int          accepted_count = 0;
   int          results_checked = 0;
   int          mismatches = 0;
   int          confirmed_count = 0;
   int          fresh_probes = 0;
   int          settings_used = 0;
   int          cycle_count = 0;
   bit          steady = 1'b0;
   bit          req_hs = 1'b0;
   logic [31:0] clock_ms = 32'd20000;

   function automatic logic [1:0] held_dir();
      if (!held_valid) return dsd_pkg::DIR_CENTER;
      return held_neg ? dsd_pkg::DIR_LEFT : dsd_pkg::DIR_RIGHT;
   endfunction

   function automatic void drop_switch();
      sw_valid = 1'b0;
      sw_neg   = 1'b0;
      sw_start = '0;
      sw_count = '0;
   endfunction

   // expected result of one item; updates the debounce state
   function automatic dsd_pkg::result_type debounce_predict(
      dsd_pkg::req_kind_type kind, logic [15:0] move_bits, logic [31:0] now);
      dsd_pkg::result_type r;
      int         mv;
      int         dz;
      int         sgn;
      bit         fresh;
      r.direction  = dsd_pkg::DIR_CENTER;
      r.reason     = dsd_pkg::RS_CENTER;
      r.hold_valid = 1'b0;
      mv = $signed(move_bits);
      dz = int'(cfg.dead_zone);
      if (kind == dsd_pkg::REQ_PROBE) begin
         fresh = held_valid && (held_stamp != 0);
         if (fresh && now > held_stamp && (now - held_stamp) > 32'(cfg.hold_ms))
            fresh = 1'b0;
         r.hold_valid = fresh;
         r.direction  = fresh ? held_dir() : dsd_pkg::DIR_CENTER;
         r.reason     = dsd_pkg::RS_PROBE;
         if (fresh) fresh_probes++;
      end else begin
         sgn = (mv > dz) ? 1 : ((mv < -dz) ? -1 : 0);
         if (sgn == 0) begin
            drop_switch();
            r.direction = held_dir();
            r.reason    = held_valid ? dsd_pkg::RS_HOLD_CENTER : dsd_pkg::RS_CENTER;
         end else if (!held_valid) begin
            held_valid = 1'b1;
            held_neg   = (sgn < 0);
            held_stamp = now;
            drop_switch();
            r.direction = (sgn > 0) ? dsd_pkg::DIR_RIGHT : dsd_pkg::DIR_LEFT;
            r.reason    = dsd_pkg::RS_INITIAL;
         end else if ((sgn < 0) == held_neg) begin
            held_stamp = now;
            drop_switch();
            r.direction = held_dir();
            r.reason    = dsd_pkg::RS_SAME;
         end else if (!sw_valid || sw_neg != (sgn < 0)) begin
            // a new opposite run starts counting
            sw_valid = 1'b1;
            sw_neg   = (sgn < 0);
            sw_start = now;
            sw_count = 8'd1;
            r.direction = held_dir();
            r.reason    = dsd_pkg::RS_PENDING;
         end else begin
            if (sw_count != 8'hFF) sw_count++;
            if (sw_count >= cfg.confirm_samples && now >= sw_start &&
                (now - sw_start) >= 32'(cfg.confirm_ms)) begin
               held_neg   = (sgn < 0);
               held_stamp = now;
               drop_switch();
               r.direction = held_dir();
               r.reason    = dsd_pkg::RS_CONFIRMED;
               confirmed_count++;
            end else begin
               r.direction = held_dir();
               r.reason    = dsd_pkg::RS_PENDING;
            end
         end
      end
      return r;
   endfunction

   // request driver, next beat set up at the falling edge
   always @(negedge clock) begin
      move_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_hs) begin
         if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
            nxt = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.kind;
            req_tdata  <= {nxt.stamp, nxt.move};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && (steady || $urandom_range(99) >= 19);
   end

   // prediction on accepted requests, checking of accepted results
   always @(posedge clock) begin
      dsd_pkg::result_type want;
      logic [1:0] got_dir;
      logic [2:0] got_reason;
      logic       got_hold;
      logic [1:0] got_pad;
      bit         bad;
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("** direction_switch_debouncer_top: FAILED **");
         $finish;
      end else if (!reset) begin
         req_hs <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            expected_results.push_back(debounce_predict(
               dsd_pkg::req_kind_type'(req_tuser), req_tdata[15:0], req_tdata[47:16]));
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_dir    = rsp_tdata[1:0];
            got_reason = rsp_tdata[4:2];
            got_hold   = rsp_tdata[5];
            got_pad    = rsp_tdata[7:6];
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: result beat %h with nothing expected", $time, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               bad = (got_dir != want.direction) || (got_reason != want.reason) ||
                     (got_hold != want.hold_valid) || (got_pad != 2'b00);
               if (bad) begin
                  mismatches++;
                  $display("%0t: result %0d exp dir=%b reason=%0d hold=%b pad=00, ",
                           $time, results_checked, want.direction, want.reason,
                           want.hold_valid,
                           "got dir=%b reason=%0d hold=%b pad=%b",
                           got_dir, got_reason, got_hold, got_pad);
               end
            end
         end
      end
   end

   task automatic push_req(dsd_pkg::req_kind_type kind, logic [15:0] mv,
                           logic [31:0] stamp);
      move_req_type it;
      it.kind  = kind;
      it.move  = mv;
      it.stamp = stamp;
      pending_reqs.push_back(it);
      sent_count++;
   endtask

   // wait until every beat is through, then let the pipeline settle
   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || accepted_count != sent_count ||
             expected_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(dsd_pkg::csr_index_type idx,
                            logic [dsd_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         dsd_pkg::CSR_DEAD_ZONE:
            cfg.dead_zone = value[dsd_pkg::DEAD_ZONE_BITS-1:0];
         dsd_pkg::CSR_SAMPLES:
            cfg.confirm_samples = value[dsd_pkg::SAMPLES_BITS-1:0];
         dsd_pkg::CSR_CONFIRM_MS: cfg.confirm_ms = value;
         dsd_pkg::CSR_HOLD_MS:    cfg.hold_ms    = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(int dz, int samples, int cms, int hold);
      drain();
      csr_write(dsd_pkg::CSR_DEAD_ZONE, 16'(dz));
      csr_write(dsd_pkg::CSR_SAMPLES, 16'(samples));
      csr_write(dsd_pkg::CSR_CONFIRM_MS, 16'(cms));
      csr_write(dsd_pkg::CSR_HOLD_MS, 16'(hold));
      settings_used++;
   endtask

   // move value of the wanted sign for the current dead zone
   function automatic logic [15:0] move_for(int d);
      int dz;
      int mag;
      dz = int'(cfg.dead_zone);
      if (d == 0) begin
         mag = $urandom_range(dz, 0);
         return 16'($urandom_range(1) ? mag : -mag);
      end
      if (d > 0 && dz >= 32767) return 16'(32767);
      case ($urandom_range(3))
         0:       mag = (d > 0) ? 32767 : 32768;
         1:       mag = dz + 1;
         default: mag = $urandom_range((d > 0) ? 32767 : 32768, dz + 1);
      endcase
      return 16'((d > 0) ? mag : -mag);
   endfunction

   // move the sample clock: mostly small steps, sometimes jumps, steps back or zero stamps
   function automatic logic [31:0] next_stamp();
      int roll;
      roll = $urandom_range(99);
      if (roll < 68)      clock_ms += $urandom_range(cfg.confirm_ms / 2 + 20, 0);
      else if (roll < 83) clock_ms += $urandom_range(2 * cfg.hold_ms + 20, 0);
      else if (roll < 88) clock_ms -= $urandom_range(200, 1);
      else if (roll < 93) return 32'd0;
      else if (roll < 96) clock_ms = 32'hFFFF_FF00 + $urandom_range(255);
      else                clock_ms = $urandom;
      return clock_ms;
   endfunction

   function automatic logic [31:0] probe_stamp();
      case ($urandom_range(9))
         0:       return 32'd0;
         1:       return clock_ms - $urandom_range(100, 1);
         2:       return $urandom;
         default: return clock_ms + $urandom_range(2 * cfg.hold_ms + 20, 0);
      endcase
   endfunction

   // a short, possibly empty stable run followed by an opposite run, some with noise in between
   task automatic switch_sequence();
      int d;
      int lead;
      int run;
      int cap;
      d    = $urandom_range(1) ? 1 : -1;
      lead = $urandom_range(2);
      cap  = (cfg.confirm_samples > 20) ? 20 : int'(cfg.confirm_samples);
      run  = $urandom_range(cap + 2, 1);
      repeat (lead) push_req(dsd_pkg::REQ_MOVE, move_for(d), next_stamp());
      repeat (run) begin
         case ($urandom_range(19))
            0: push_req(dsd_pkg::REQ_MOVE, move_for(0), next_stamp());
            1: push_req(dsd_pkg::REQ_PROBE, 16'($urandom), probe_stamp());
            default: ;
         endcase
         push_req(dsd_pkg::REQ_MOVE, move_for(-d), next_stamp());
      end
   endtask

   task automatic random_traffic(int n_items);
      int target;
      int roll;
      target = sent_count + n_items;
      while (sent_count < target) begin
         roll = $urandom_range(99);
         if (roll < 60)
            switch_sequence();
         else if (roll < 80)
            push_req(dsd_pkg::REQ_PROBE, 16'($urandom), probe_stamp());
         else
            push_req(dsd_pkg::req_kind_type'($urandom_range(1)), 16'($urandom),
                     $urandom_range(1) ? next_stamp() : 32'($urandom));
      end
   endtask

   // long opposite run that drives the pending count into saturation
   task automatic saturation_run();
      int d;
      d = held_valid ? (held_neg ? -1 : 1) : -1;
      push_req(dsd_pkg::REQ_MOVE, move_for(d), clock_ms);
      for (int i = 1; i <= 290; i++) begin
         if (i % 60 == 0)
            push_req(dsd_pkg::REQ_PROBE, 16'($urandom), clock_ms + 32'(i));
         push_req(dsd_pkg::REQ_MOVE, move_for(-d), clock_ms + 32'(i));
      end
      clock_ms += 32'd70000;
      push_req(dsd_pkg::REQ_MOVE, move_for(-d), clock_ms);
      push_req(dsd_pkg::REQ_PROBE, 16'h0000, clock_ms + 32'd10);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed items at the reset settings
      push_req(dsd_pkg::REQ_PROBE, 16'h8000, 32'd0);
      push_req(dsd_pkg::REQ_MOVE, 16'h0000, 32'd10);
      push_req(dsd_pkg::REQ_MOVE, 16'd256, 32'd20);
      push_req(dsd_pkg::REQ_MOVE, -16'sd256, 32'd30);
      push_req(dsd_pkg::REQ_MOVE, 16'd257, 32'd1000);
      push_req(dsd_pkg::REQ_PROBE, 16'h7FFF, 32'd1200);
      push_req(dsd_pkg::REQ_PROBE, 16'h0000, 32'd1500);
      push_req(dsd_pkg::REQ_PROBE, 16'h0000, 32'd1501);
      push_req(dsd_pkg::REQ_PROBE, 16'h0000, 32'd900);
      push_req(dsd_pkg::REQ_MOVE, 16'h7FFF, 32'd1100);
      push_req(dsd_pkg::REQ_MOVE, 16'h8000, 32'd1150);
      push_req(dsd_pkg::REQ_MOVE, -16'sd257, 32'd1160);
      push_req(dsd_pkg::REQ_MOVE, -16'sd300, 32'd1250);
      push_req(dsd_pkg::REQ_MOVE, 16'h0000, 32'd1260);
      push_req(dsd_pkg::REQ_MOVE, 16'd400, 32'd1270);
      push_req(dsd_pkg::REQ_MOVE, 16'h0000, 32'd1280);
      push_req(dsd_pkg::REQ_MOVE, 16'd400, 32'd5000);
      push_req(dsd_pkg::REQ_MOVE, 16'd400, 32'd4000);
      push_req(dsd_pkg::REQ_MOVE, 16'd400, 32'd3000);
      push_req(dsd_pkg::REQ_MOVE, 16'd400, 32'd5100);
      push_req(dsd_pkg::REQ_MOVE, 16'd500, 32'd0);
      push_req(dsd_pkg::REQ_PROBE, 16'h0000, 32'd100);
      push_req(dsd_pkg::REQ_PROBE, 16'h7FFF, 32'hFFFF_FFFF);
      push_req(dsd_pkg::REQ_MOVE, -16'sd1000, 32'hFFFF_FFFF);
      push_req(dsd_pkg::REQ_MOVE, -16'sd1000, 32'd50);

      // extremes of the register ranges
      apply_settings(0, 1, 0, 0);
      random_traffic(80);
      apply_settings(32767, 255, 65535, 65535);
      random_traffic(50);

      // zero sample count, no idling on either side
      apply_settings(256, 0, 100, 500);
      steady = 1'b1;
      random_traffic(100);
      drain();
      steady = 1'b0;

      apply_settings(100, 255, 65535, 65535);
      saturation_run();

      repeat (3) begin
         apply_settings($urandom_range(2000), $urandom_range(8, 1), $urandom_range(300),
                        $urandom_range(1000));
         random_traffic(70);
      end
      drain();

      if (expected_results.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected results never arrived", $time,
                  expected_results.size());
      end
      $display("checked %0d results from %0d requests over %0d register settings",
               results_checked, accepted_count, settings_used + 1);
      $display("%0d direction switches confirmed, %0d probes found a fresh hold",
               confirmed_count, fresh_probes);
      if (mismatches == 0) begin
         $display("** direction_switch_debouncer_top: PASSED **");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("** direction_switch_debouncer_top: FAILED **");
      end
      $finish;
   end
endmodule
